### hdl/mcc_pkg.sv
// Shared types, constants and codes for the minimum coin change core.
package mcc_pkg;

  // Field and register widths.
  localparam int unsigned AMT_W      = 12;
  localparam int unsigned COIN_W     = 12;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TBL_W      = 13;
  localparam int unsigned CALC_W     = 17;
  localparam int unsigned KIDX_W     = 3;
  localparam int unsigned NUM_COIN_REGS = 6;

  // Defaults for the top level parameters.
  localparam int unsigned DEF_MAX_AMOUNT = 4095;
  localparam int unsigned DEF_MAX_COINS  = 6;

  // Table code for an amount that no combination of coins reaches.
  localparam logic [TBL_W-1:0] UNREACHED = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_5 = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FILL,
    ST_WRITE,
    ST_FINISH
  } mcc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              init;
    logic              issue;
    logic              write;
    logic              publish;
    logic [KIDX_W-1:0] coin_idx;
  } mcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic               tgt_over;
    logic               tgt_zero;
    logic               amt_last;
    logic [COUNT_W-1:0] ncoins;
  } mcc_sts_t;

endpackage

### hdl/mcc_ctrl.sv
// Controller state machine that sequences the table fill for one request.
module mcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mcc_pkg::mcc_sts_t sts_i,
  output mcc_pkg::mcc_cmd_t cmd_o
);
  import mcc_pkg::*;

  mcc_state_e        state_q, state_d;
  logic [KIDX_W-1:0] k_q, k_d;
  logic              out_valid_q, out_valid_d;
  logic              coin_last;

  assign coin_last = (sts_i.ncoins == '0) ||
                     (k_q == KIDX_W'(sts_i.ncoins - COUNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.coin_idx = k_q;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.tgt_over ? ST_FINISH : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        k_d        = '0;
        state_d    = sts_i.tgt_zero ? ST_FINISH : ST_FILL;
      end
      ST_FILL: begin
        cmd_o.issue = 1'b1;
        if (coin_last) begin
          state_d = ST_WRITE;
        end else begin
          k_d = k_q + KIDX_W'(1);
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        k_d         = '0;
        state_d     = sts_i.amt_last ? ST_FINISH : ST_FILL;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/mcc_datapath.sv
// Datapath: coin registers, minimum count table, compare-update unit and result registers.
module mcc_datapath #(
  parameter int unsigned MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT,
  parameter int unsigned MAX_COINS  = mcc_pkg::DEF_MAX_COINS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mcc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [mcc_pkg::AMT_W-1:0]       target_amount_i,
  input  mcc_pkg::mcc_cmd_t               cmd_i,
  output mcc_pkg::mcc_sts_t               sts_o,
  output logic [mcc_pkg::AMT_W-1:0]       min_coins_o,
  output logic                            impossible_o
);
  import mcc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_AMOUNT + 1);
  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam logic [CALC_W-1:0]  MaxAmt   = CALC_W'(MAX_AMOUNT);
  localparam logic [COUNT_W-1:0] MaxCoins = COUNT_W'(MAX_COINS);

  logic [COUNT_W-1:0] coin_count_q;
  logic [COIN_W-1:0]  coin_q [NUM_COIN_REGS];

  logic [AW-1:0]     target_q, amt_q;
  logic [TBL_W-1:0]  best_q, rd_data_q, cand;
  logic              rd_valid_q;
  logic [AMT_W-1:0]  res_min_q, out_min_q;
  logic              res_imp_q, out_imp_q;

  logic [TBL_W-1:0]  tbl_mem [DEPTH];

  logic [CALC_W-1:0]  tgt_ext, amt_ext, coin_ext, diff;
  logic [COIN_W-1:0]  coin_sel;
  logic [COUNT_W-1:0] ncoins;
  logic               usable, better, wr_en;
  logic [AW-1:0]      wr_addr;
  logic [TBL_W-1:0]   wr_data;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_count_q <= COUNT_W'(1);
      for (int i = 0; i < NUM_COIN_REGS; i++) begin
        coin_q[i] <= COIN_W'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_COIN_COUNT) begin
        coin_count_q <= cfg_data_i[COUNT_W-1:0];
      end else if (cfg_idx_i inside {[REG_COIN_VALUE_0:REG_COIN_VALUE_5]}) begin
        coin_q[cfg_idx_i - REG_COIN_VALUE_0] <= cfg_data_i[COIN_W-1:0];
      end
    end
  end

  assign ncoins   = (coin_count_q > MaxCoins) ? MaxCoins : coin_count_q;
  assign tgt_ext  = CALC_W'(target_amount_i);
  assign amt_ext  = CALC_W'(amt_q);
  assign coin_sel = (cmd_i.coin_idx < KIDX_W'(NUM_COIN_REGS)) ?
                    coin_q[cmd_i.coin_idx] : '0;
  assign coin_ext = CALC_W'(coin_sel);
  assign diff     = amt_ext - coin_ext;
  assign usable   = (COUNT_W'(cmd_i.coin_idx) < ncoins) && (coin_sel != '0) &&
                    (coin_ext <= amt_ext);

  // A reachable predecessor plus one coin replaces the running best when smaller.
  assign better = rd_valid_q && (rd_data_q != UNREACHED) &&
                  ((rd_data_q + TBL_W'(1)) < best_q);
  assign cand   = better ? (rd_data_q + TBL_W'(1)) : best_q;

  assign wr_en   = cmd_i.init || cmd_i.write;
  assign wr_addr = cmd_i.init ? '0 : amt_q;
  assign wr_data = cmd_i.init ? '0 : cand;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.issue) begin
      rd_data_q <= tbl_mem[diff[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.issue && usable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= tgt_ext[AW-1:0];
      if (tgt_ext > MaxAmt) begin
        res_min_q <= '0;
        res_imp_q <= 1'b1;
      end
    end
    if (cmd_i.init) begin
      amt_q  <= AW'(1);
      best_q <= UNREACHED;
      if (target_q == '0) begin
        res_min_q <= '0;
        res_imp_q <= 1'b0;
      end
    end
    if (cmd_i.issue) begin
      best_q <= cand;
    end
    if (cmd_i.write) begin
      amt_q  <= amt_q + AW'(1);
      best_q <= UNREACHED;
      if (amt_q == target_q) begin
        res_min_q <= (cand == UNREACHED) ? '0 : cand[AMT_W-1:0];
        res_imp_q <= (cand == UNREACHED);
      end
    end
    if (cmd_i.publish) begin
      out_min_q <= res_min_q;
      out_imp_q <= res_imp_q;
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.tgt_over = (tgt_ext > MaxAmt);
    sts_o.tgt_zero = (target_q == '0);
    sts_o.amt_last = (amt_q == target_q);
    sts_o.ncoins   = ncoins;
  end

  assign min_coins_o  = out_min_q;
  assign impossible_o = out_imp_q;

endmodule

### hdl/min_coin_change_dp_core.sv
// Top level of the minimum coin change core: stream ports, config port, controller and datapath.
//
//  Channel   Direction  Payload                                    Transfer when
//  s_axis    in         tdata[11:0] target_amount                  tvalid & tready
//  m_axis    out        tdata[11:0] min_coins, tuser[0] impossible tvalid & tready
//  cfg       in         cfg_idx_i register, cfg_data_i value       cfg_we_i
//
// A request for amount T walks amounts 1 to T; each amount takes at least one read slot
// even with no coins in use. The table memory has a single read port, so each amount
// reads one predecessor per coin, one per cycle, and then writes its own entry. Amount
// zero and an amount above MAX_AMOUNT skip the table fill. Reset restores one coin of
// value one; the table itself is not cleared because every request rewrites the entries
// it reads. A finished result waits in the output register while the next request is
// accepted.
module min_coin_change_dp_core #(
  parameter int unsigned MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT,
  parameter int unsigned MAX_COINS  = mcc_pkg::DEF_MAX_COINS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [11:0] target_amount, [15:12] zero
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [11:0] min_coins, [15:12] zero
  output logic                           m_axis_tuser   // [0] impossible
);
  import mcc_pkg::*;

  mcc_cmd_t          cmd;
  mcc_sts_t          sts;
  logic [AMT_W-1:0]  min_coins;
  logic              impossible;

  // The controller owns the handshakes and the coin and amount sequencing.
  mcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the coin registers, the table and the running minimum.
  mcc_datapath #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .MAX_COINS  (MAX_COINS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .target_amount_i (s_axis_tdata[AMT_W-1:0]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .min_coins_o     (min_coins),
    .impossible_o    (impossible)
  );

  assign m_axis_tdata = {4'b0000, min_coins};
  assign m_axis_tuser = impossible;

endmodule

### dv/min_coin_change_dp_core_test.sv
// Self-checking testbench for the minimum coin change core: directed and random requests.
`timescale 1ns / 100ps

module min_coin_change_dp_core_test;
  import mcc_pkg::*;

  // The instance keeps its default table size and coin limit.
  localparam int unsigned TOP_AMOUNT = DEF_MAX_AMOUNT;
  localparam int unsigned COIN_LIMIT = DEF_MAX_COINS;

  // Register index that lies past the last coin value and must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_COIN_VALUE_5 + 3'd1;

  // The slowest request walks all 4095 amounts with six coins in use, so a
  // stretch of this many cycles without any transfer means the core has hung.
  localparam int unsigned STALL_LIMIT = 200000;

  // One result as the core should report it.
  typedef struct packed {
    logic [AMT_W-1:0] min_coins;
    logic             impossible;
  } change_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tuser;

  // Shadow copy of the configuration registers, updated on every write.
  logic [COUNT_W-1:0] coin_count_q;
  logic [COIN_W-1:0]  coin_value_q [NUM_COIN_REGS];

  // Table of fewest coins per amount, rebuilt for each request.
  logic [TBL_W-1:0] fewest_table [0:TOP_AMOUNT];

  // Answers owed by the core, oldest first.
  change_t owed_answers [$];

  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  int ready_hold      = 0;
  int mismatches      = 0;
  int requests_sent   = 0;
  int answers_checked = 0;
  int impossible_seen = 0;
  int reg_writes      = 0;
  int largest_amount  = 0;
  int quiet_cycles    = 0;

  always #1 clk_i = ~clk_i;

  min_coin_change_dp_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Builds the table from zero up to the amount with the coins currently
  // configured. Each entry is the best predecessor count plus one; a coin of
  // value zero, a coin larger than the amount and an unreachable predecessor
  // never contribute. A count above the coin limit is clamped to the limit.
  function automatic change_t fewest_coins_for(input logic [AMT_W-1:0] amount);
    int unsigned in_use;
    int unsigned best;
    int unsigned coin;
    change_t     answer;
    in_use = (coin_count_q > COIN_LIMIT) ? COIN_LIMIT : coin_count_q;
    answer.min_coins  = '0;
    answer.impossible = 1'b1;
    if (amount > TOP_AMOUNT) begin
      return answer;
    end
    fewest_table[0] = '0;
    for (int unsigned amt = 1; amt <= amount; amt++) begin
      best = UNREACHED;
      for (int unsigned k = 0; k < in_use; k++) begin
        coin = coin_value_q[k];
        if (coin != 0 && coin <= amt) begin
          if (fewest_table[amt - coin] != UNREACHED &&
              int'(fewest_table[amt - coin]) + 1 < best) begin
            best = int'(fewest_table[amt - coin]) + 1;
          end
        end
      end
      fewest_table[amt] = best[TBL_W-1:0];
    end
    if (fewest_table[amount] != UNREACHED) begin
      answer.min_coins  = fewest_table[amount][AMT_W-1:0];
      answer.impossible = 1'b0;
    end
    return answer;
  endfunction

  // Offers one amount on the request stream, starting at a falling edge, and
  // returns at the falling edge after the transfer. The valid stays high on
  // return: the caller either offers the next amount or lowers it at once,
  // before any time passes, so the core never sees a request twice.
  task automatic send_amount(input logic [AMT_W-1:0] amount);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, amount};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    owed_answers.insert(owed_answers.size(), fewest_coins_for(amount));
    requests_sent++;
    if (amount > largest_amount) largest_amount = amount;
    @(negedge clk_i);
  endtask

  // Stops offering, waits for every owed answer, then lets a few more cycles
  // pass so that the core is back in its idle state before registers change.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (owed_answers.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Writes one register and keeps the shadow copy in step. The enable is left
  // high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_COIN_COUNT) begin
      coin_count_q = data[COUNT_W-1:0];
    end else if (idx inside {[REG_COIN_VALUE_0:REG_COIN_VALUE_5]}) begin
      coin_value_q[idx - REG_COIN_VALUE_0] = data;
    end
    reg_writes++;
    @(negedge clk_i);
  endtask

  // Loads a whole coin set once the core has gone quiet.
  task automatic apply_coins(input logic [COUNT_W-1:0] count,
                             input logic [COIN_W-1:0] c0, input logic [COIN_W-1:0] c1,
                             input logic [COIN_W-1:0] c2, input logic [COIN_W-1:0] c3,
                             input logic [COIN_W-1:0] c4, input logic [COIN_W-1:0] c5);
    wait_idle();
    write_reg(REG_COIN_COUNT, CFG_DATA_W'(count));
    write_reg(REG_COIN_VALUE_0,        c0);
    write_reg(REG_COIN_VALUE_0 + 3'd1, c1);
    write_reg(REG_COIN_VALUE_0 + 3'd2, c2);
    write_reg(REG_COIN_VALUE_0 + 3'd3, c3);
    write_reg(REG_COIN_VALUE_0 + 3'd4, c4);
    write_reg(REG_COIN_VALUE_5,        c5);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small coins, now and then a zero or a large one.
  function automatic logic [COIN_W-1:0] random_coin();
    int unsigned pick;
    pick = $urandom_range(11);
    if (pick == 0) return '0;
    if (pick == 1) return COIN_W'($urandom_range(4095, 1));
    return COIN_W'($urandom_range(30, 1));
  endfunction

  task automatic randomize_coins();
    logic [COUNT_W-1:0] count;
    count = ($urandom_range(9) < 8) ? COUNT_W'($urandom_range(6, 1))
                                    : (($urandom_range(1) == 0) ? 3'd0 : 3'd7);
    apply_coins(count, random_coin(), random_coin(), random_coin(),
                random_coin(), random_coin(), random_coin());
  endtask

  // Small amounts keep the run short; one request in twenty is drawn from
  // the whole range so that the high amount bits toggle.
  function automatic logic [AMT_W-1:0] random_amount();
    if ($urandom_range(19) == 0) return AMT_W'($urandom_range(4095));
    return AMT_W'($urandom_range(120));
  endfunction

  // After reset the core holds a single coin of value one.
  task automatic test_reset_coins();
    coin_count_q = 3'd1;
    for (int k = 0; k < NUM_COIN_REGS; k++) coin_value_q[k] = 12'd1;
    send_amount(12'd0);
    send_amount(12'd1);
    send_amount(12'd5);
    send_amount(12'd4095);
  endtask

  // Coin counts of zero and above the limit, coins of value zero, and a write
  // to the unused register index.
  task automatic test_coin_count_edges();
    apply_coins(3'd0, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    send_amount(12'd0);
    send_amount(12'd3);
    apply_coins(3'd3, 12'd0, 12'd4, 12'd0, 12'd1, 12'd1, 12'd1);
    send_amount(12'd8);
    send_amount(12'd9);
    apply_coins(3'd7, 12'd9, 12'd9, 12'd9, 12'd9, 12'd9, 12'd2);
    send_amount(12'd4);
    send_amount(12'd27);
    wait_idle();
    write_reg(REG_UNUSED, 12'hFFF);
    cfg_we_i <= 1'b0;
    send_amount(12'd6);
  endtask

  // Classic coin sets, coins larger than the remainder, parity gaps, and the
  // longest request: the top amount with all six coins in use.
  task automatic test_coin_sets();
    apply_coins(3'd4, 12'd1, 12'd5, 12'd10, 12'd25, 12'd0, 12'd0);
    send_amount(12'd30);
    send_amount(12'd63);
    apply_coins(3'd1, 12'd2, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    send_amount(12'd7);
    send_amount(12'd8);
    apply_coins(3'd2, 12'd7, 12'd3, 12'd1, 12'd1, 12'd1, 12'd1);
    send_amount(12'd11);
    send_amount(12'd13);
    apply_coins(3'd1, 12'd2048, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
    send_amount(12'd2048);
    apply_coins(3'd6, 12'd4095, 12'd2048, 12'd1024, 12'd7, 12'd3, 12'd1);
    send_amount(12'd4095);
  endtask

  task automatic test_random_phase(input int send_idle, input int take_idle, input int items);
    sender_idle_pct = send_idle;
    recv_idle_pct   = take_idle;
    for (int i = 0; i < items; i++) begin
      if (i % 11 == 0) randomize_coins();
      send_amount(random_amount());
    end
  endtask

  // The receiver refuses results for a long stretch while requests keep
  // coming, so the output register fills and the request side must stall.
  task automatic test_result_backpressure();
    apply_coins(3'd3, 12'd1, 12'd3, 12'd4, 12'd1, 12'd1, 12'd1);
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    ready_hold      = 400;
    for (int i = 0; i < 8; i++) send_amount(AMT_W'($urandom_range(20)));
    wait_idle();
  endtask

  // Receiver side: the ready changes only at falling edges.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      m_axis_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s for result %0d: expected %0d, got %0d",
               what, answers_checked, want, got);
    end
  endtask

  // Every result transfer is checked against the oldest owed answer.
  always @(posedge clk_i) begin
    change_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_answers.size() == 0) begin
        note_mismatch("an unrequested result", 0, m_axis_tdata[AMT_W-1:0]);
      end else begin
        want = owed_answers.pop_front();
        if (m_axis_tdata[AMT_W-1:0] !== want.min_coins) begin
          note_mismatch("min_coins", want.min_coins, m_axis_tdata[AMT_W-1:0]);
        end
        if (m_axis_tuser !== want.impossible) begin
          note_mismatch("impossible", want.impossible, m_axis_tuser);
        end
        if (want.impossible) impossible_seen++;
      end
      answers_checked++;
    end
  end

  // Watchdog: any transfer on either stream restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d answers still owed",
                 quiet_cycles, owed_answers.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    sender_idle_pct = 18;
    recv_idle_pct   = 76;
    test_reset_coins();
    test_coin_count_edges();
    test_coin_sets();

    test_random_phase(18, 76, 25);
    test_random_phase(76, 18, 25);
    test_random_phase(0, 0, 26);
    test_result_backpressure();

    wait_idle();
    repeat (20) @(negedge clk_i);

    $display("%0d requests (largest amount %0d) gave %0d checked results, %0d impossible,",
             requests_sent, largest_amount, answers_checked, impossible_seen);
    $display("over %0d register writes and three idling mixes plus one long result stall",
             reg_writes);
    if (mismatches == 0 && owed_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d answers never came", mismatches, owed_answers.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
